### sv/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared constants and the CORDIC angle table for the odometry core.
// ----------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

  localparam int unsigned CordicIters = 24;
  localparam int unsigned IterW       = 5;

  localparam logic signed [31:0] PI_Q        = 32'sd843314857;
  localparam logic signed [32:0] TWO_PI_Q    = 33'sd1686629714;
  localparam logic signed [31:0] HALF_PI_Q   = 32'sd421657428;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [7:0] CFG_START_X   = 8'd0;
  localparam logic [7:0] CFG_START_Y   = 8'd1;
  localparam logic [7:0] CFG_START_H   = 8'd2;
  localparam logic [7:0] CFG_RADIUS    = 8'd3;
  localparam logic [7:0] CFG_INV_AXIS  = 8'd4;
  localparam logic [7:0] CFG_INV_STEP  = 8'd5;

  // round(atan(2^-i) * 2^28)
  function automatic logic signed [31:0] atan_q28(input logic [IterW-1:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:  v = 32'sd210828714;
      5'd1:  v = 32'sd124459457;
      5'd2:  v = 32'sd65760959;
      5'd3:  v = 32'sd33381290;
      5'd4:  v = 32'sd16755422;
      5'd5:  v = 32'sd8385879;
      5'd6:  v = 32'sd4193963;
      5'd7:  v = 32'sd2097109;
      5'd8:  v = 32'sd1048571;
      5'd9:  v = 32'sd524287;
      5'd10: v = 32'sd262144;
      5'd11: v = 32'sd131072;
      5'd12: v = 32'sd65536;
      5'd13: v = 32'sd32768;
      5'd14: v = 32'sd16384;
      5'd15: v = 32'sd8192;
      5'd16: v = 32'sd4096;
      5'd17: v = 32'sd2048;
      5'd18: v = 32'sd1024;
      5'd19: v = 32'sd512;
      5'd20: v = 32'sd256;
      5'd21: v = 32'sd128;
      5'd22: v = 32'sd64;
      5'd23: v = 32'sd32;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### sv/ddo_mul.sv
// ----------------------------------------------------------------------------
// ddo_mul
// Shared signed 33x33 multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_mul (
  input  wire logic               clk_i,
  input  wire logic signed [32:0] a_i,
  input  wire logic signed [32:0] b_i,
  output logic signed [65:0]      p_o
);

  logic signed [65:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

### sv/ddo_cordic.sv
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, Q.30 cos/sin.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_cordic
  import ddo_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] angle_i,
  output logic                    done_o,
  output logic signed [32:0]      cos_o,
  output logic signed [32:0]      sin_o
);

  logic signed [33:0] x_q, y_q;
  logic signed [31:0] z_q;
  logic [IterW-1:0]   iter_q;
  logic               busy_q, done_q, neg_q;
  logic signed [33:0] dx, dy, xo, yo;
  logic signed [31:0] at;

  assign dx = y_q >>> iter_q;
  assign dy = x_q >>> iter_q;
  assign at = atan_q28(iter_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      iter_q <= '0;
    end else if (busy_q) begin
      iter_q <= iter_q + 1'b1;
      if (iter_q == IterW'(CordicIters - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= CORDIC_GAIN;
      y_q <= '0;
      if (angle_i > HALF_PI_Q) begin
        z_q   <= angle_i - PI_Q;
        neg_q <= 1'b1;
      end else if (angle_i < -HALF_PI_Q) begin
        z_q   <= angle_i + PI_Q;
        neg_q <= 1'b1;
      end else begin
        z_q   <= angle_i;
        neg_q <= 1'b0;
      end
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  assign xo     = neg_q ? -x_q : x_q;
  assign yo     = neg_q ? -y_q : y_q;
  assign cos_o  = xo[32:0];
  assign sin_o  = yo[32:0];
  assign done_o = done_q;

endmodule

`default_nettype wire

### sv/differential_drive_odometry_core.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry_core
// Wheel odometry: encoder angle pair in, pose and velocity out.
//
//  channel | dir | payload
//  s_*     | in  | tdata[31:0] left_wheel_angle, [63:32] right_wheel_angle
//  m_*     | out | tdata x, y, heading, velocity_x, velocity_y
//  cfg_*   | in  | cfg_index_i register index, cfg_data_i value
//
// The result of a beat is presented once the sequencer has waited on the
// 24-step CORDIC and run its sequence of products through the single
// shared multiplier; the next beat can be taken once the sequencer is back
// in idle, so a new beat is taken only after the last one reaches the output register.
// s_tready_o is high only while the sequencer is idle.
// A finished result waits in the output register; the next beat may be
// taken meanwhile and stalls only at its final write-back.
// Reset clears the pose and the previous angles; the first beat loads the
// start pose.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_odometry_core
  import ddo_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_tvalid_i,
  output logic              s_tready_o,
  input  wire logic [63:0]  s_tdata_i,   // left_wheel_angle, right_wheel_angle
  output logic              m_tvalid_o,
  input  wire logic         m_tready_i,
  output logic [159:0]      m_tdata_o,   // pose_x, pose_y, heading,
                                         // velocity_x, velocity_y, pad
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [7:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TL   = 4'd1;
  localparam logic [3:0] S_TR   = 4'd2;
  localparam logic [3:0] S_DD   = 4'd3;
  localparam logic [3:0] S_AH   = 4'd4;
  localparam logic [3:0] S_AL   = 4'd5;
  localparam logic [3:0] S_TN   = 4'd6;
  localparam logic [3:0] S_PX   = 4'd7;
  localparam logic [3:0] S_PY   = 4'd8;
  localparam logic [3:0] S_QX   = 4'd9;
  localparam logic [3:0] S_VXH  = 4'd10;
  localparam logic [3:0] S_VXL  = 4'd11;
  localparam logic [3:0] S_VYH  = 4'd12;
  localparam logic [3:0] S_VYL  = 4'd13;
  localparam logic [3:0] S_FIN  = 4'd14;

  logic [3:0] state_q, state_d;

  logic [31:0]        start_x_q, start_y_q;
  logic [30:0]        start_h_q;
  logic [15:0]        radius_q;
  logic [23:0]        inv_axis_q, inv_step_q;

  logic [31:0]        last_l_q, last_r_q, pos_x_q, pos_y_q;
  logic signed [31:0] head_q;
  logic               loaded_q;

  logic signed [31:0] dl_q, dr_q, disp_q, turn_q, vx_q;
  logic signed [47:0] tl_q;
  logic signed [40:0] diff_q;
  logic signed [65:0] acc_q;
  logic signed [63:0] px_q;
  logic signed [38:0] qx_q, qy_q;

  logic               m_valid_q;
  logic [159:0]       m_data_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic               cor_done;
  logic signed [32:0] cos_v, sin_v;

  logic               in_acc, fin_go;
  logic signed [31:0] start_h_sat, head_start;
  logic signed [30:0] start_h_s;
  logic signed [48:0] sum_t, dif_t, disp_r;
  logic signed [31:0] disp_sat;
  logic signed [40:0] diff_sat;
  logic signed [65:0] tot, turn_r, vel_r;
  logic signed [31:0] turn_sat, vel_sat;
  logic signed [63:0] pyv, rx, ry;
  logic signed [32:0] h_sum, h_wrap;

  assign s_tready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = s_tvalid_i & s_tready_o;
  assign fin_go      = (state_q == S_FIN) & (~m_valid_q | m_tready_i);

  assign start_h_s   = signed'(start_h_q);
  assign start_h_sat = (32'(start_h_s) > PI_Q)  ? PI_Q :
                       (32'(start_h_s) < -PI_Q) ? -PI_Q : 32'(start_h_s);
  assign head_start  = loaded_q ? head_q : start_h_sat;

  ddo_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  ddo_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .angle_i (head_start),
    .done_o  (cor_done),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  // combinational arithmetic around the multiplier
  assign sum_t    = 49'(tl_q) + 49'(signed'(prod[47:0]));
  assign disp_r   = (sum_t + 49'sd256) >>> 9;
  assign disp_sat = (disp_r > 49'sd2147483647)  ? 32'sh7fffffff :
                    (disp_r < -49'sd2147483648) ? 32'sh80000000 : disp_r[31:0];
  assign dif_t    = 49'(signed'(prod[47:0])) - 49'(tl_q);
  assign diff_sat = (dif_t > 49'sd549755813888)  ? 41'sd549755813888 :
                    (dif_t < -49'sd549755813888) ? -41'sd549755813888 : dif_t[40:0];
  assign tot      = acc_q + prod;
  assign turn_r   = -((tot + 66'sd524288) >>> 20);
  assign turn_sat = (turn_r > 66'(TWO_PI_Q))  ? TWO_PI_Q[31:0] :
                    (turn_r < -66'(TWO_PI_Q)) ? -TWO_PI_Q[31:0] : turn_r[31:0];
  assign vel_r    = (tot + 66'sd8388608) >>> 24;
  assign vel_sat  = (vel_r > 66'sd2147483647)  ? 32'sh7fffffff :
                    (vel_r < -66'sd2147483648) ? 32'sh80000000 : vel_r[31:0];
  assign pyv      = prod[63:0];
  assign rx       = (px_q + 64'sd536870912) >>> 30;
  assign ry       = (pyv + 64'sd536870912) >>> 30;
  assign h_sum    = 33'(head_q) + 33'(turn_q);
  always_comb begin
    h_wrap = h_sum;
    if (h_wrap > 33'(PI_Q)) h_wrap = h_wrap - TWO_PI_Q;
    if (h_wrap < -33'(PI_Q)) h_wrap = h_wrap + TWO_PI_Q;
  end

  // multiplier operand select; operands held while waiting in TN and FIN
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_TL:  begin mul_a = 33'(dl_q); mul_b = {17'b0, radius_q}; end
      S_TR:  begin mul_a = 33'(dr_q); mul_b = {17'b0, radius_q}; end
      S_AH:  begin mul_a = 33'(signed'(diff_q[40:16])); mul_b = {9'b0, inv_axis_q}; end
      S_AL, S_TN: begin
        mul_a = {17'b0, diff_q[15:0]}; mul_b = {9'b0, inv_axis_q};
      end
      S_PX:  begin mul_a = 33'(disp_q); mul_b = cos_v; end
      S_PY:  begin mul_a = 33'(disp_q); mul_b = sin_v; end
      S_VXH: begin mul_a = 33'(signed'(qx_q[38:16])); mul_b = {9'b0, inv_step_q}; end
      S_VXL: begin mul_a = {17'b0, qx_q[15:0]}; mul_b = {9'b0, inv_step_q}; end
      S_VYH: begin mul_a = 33'(signed'(qy_q[38:16])); mul_b = {9'b0, inv_step_q}; end
      S_VYL, S_FIN: begin
        mul_a = {17'b0, qy_q[15:0]}; mul_b = {9'b0, inv_step_q};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc) state_d = S_TL;
      S_TL:   state_d = S_TR;
      S_TR:   state_d = S_DD;
      S_DD:   state_d = S_AH;
      S_AH:   state_d = S_AL;
      S_AL:   state_d = S_TN;
      S_TN:   if (cor_done) state_d = S_PX;
      S_PX:   state_d = S_PY;
      S_PY:   state_d = S_QX;
      S_QX:   state_d = S_VXH;
      S_VXH:  state_d = S_VXL;
      S_VXL:  state_d = S_VYH;
      S_VYH:  state_d = S_VYL;
      S_VYL:  state_d = S_FIN;
      S_FIN:  if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      start_x_q  <= '0;
      start_y_q  <= '0;
      start_h_q  <= '0;
      radius_q   <= 16'd1311;
      inv_axis_q <= 24'd1260308;
      inv_step_q <= 24'd524288;
      last_l_q   <= '0;
      last_r_q   <= '0;
      pos_x_q    <= '0;
      pos_y_q    <= '0;
      head_q     <= '0;
      loaded_q   <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_START_X:  start_x_q  <= cfg_data_i;
          CFG_START_Y:  start_y_q  <= cfg_data_i;
          CFG_START_H:  start_h_q  <= cfg_data_i[30:0];
          CFG_RADIUS:   radius_q   <= cfg_data_i[15:0];
          CFG_INV_AXIS: inv_axis_q <= cfg_data_i[23:0];
          CFG_INV_STEP: inv_step_q <= cfg_data_i[23:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        last_l_q <= s_tdata_i[31:0];
        last_r_q <= s_tdata_i[63:32];
        loaded_q <= 1'b1;
        if (!loaded_q) begin
          pos_x_q <= start_x_q;
          pos_y_q <= start_y_q;
          head_q  <= start_h_sat;
        end
      end
      if (state_q == S_QX) begin
        pos_x_q <= pos_x_q + rx[31:0];
        pos_y_q <= pos_y_q + ry[31:0];
      end
      if (fin_go) begin
        head_q    <= h_wrap[31:0];
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dl_q <= s_tdata_i[31:0] - last_l_q;
      dr_q <= s_tdata_i[63:32] - last_r_q;
    end
    case (state_q)
      S_TR:  tl_q <= prod[47:0];
      S_DD:  begin disp_q <= disp_sat; diff_q <= diff_sat; end
      S_AL:  acc_q <= prod <<< 16;
      S_TN:  turn_q <= turn_sat;
      S_PY:  px_q <= prod[63:0];
      S_QX:  begin
        qx_q <= 39'((px_q + 64'sd8388608) >>> 24);
        qy_q <= 39'((pyv + 64'sd8388608) >>> 24);
      end
      S_VXL: acc_q <= prod <<< 16;
      S_VYH: vx_q <= vel_sat;
      S_VYL: acc_q <= prod <<< 16;
      default: ;
    endcase
    if (fin_go) begin
      m_data_q <= {1'b0, vel_sat, vx_q, h_wrap[30:0], pos_y_q, pos_x_q};
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

  a_acc_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_TL)
    else $error("accepted beat did not start the sequence");

  a_cordic_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PX |-> cor_done)
    else $error("products issued before CORDIC finished");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q |-> (head_q <= PI_Q) && (head_q >= -PI_Q))
    else $error("heading out of range");

  a_fin_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> m_valid_q && state_q == S_IDLE)
    else $error("result not presented after final step");

endmodule

`default_nettype wire

### test/differential_drive_odometry_core_test.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry_core_test
// Self-checking bench for the wheel odometry core. A local fixed-point model
// tracks the encoder angles, the pose and the settings, predicts the pose and
// velocity for every accepted encoder beat, and compares each output beat
// field by field. Directed start-pose and extreme cases come first. Random
// motion then runs under three stall patterns, with new settings between them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module differential_drive_odometry_core_test;
  import ddo_pkg::*;

  localparam longint PiQ      = 843314857;
  localparam longint TwoPiQ   = 1686629714;
  localparam longint HalfPiQ  = 421657428;
  localparam longint Gain     = 652032874;
  localparam longint I32Min   = -64'sd2147483648;
  localparam longint I32Max   = 64'sd2147483647;
  localparam int     Latency  = 60;
  localparam int     MaxCycles = 2000000;
  localparam logic [7:0] CFG_UNUSED = 8'd9;

  typedef struct packed {
    logic [31:0] pose_x;
    logic [31:0] pose_y;
    logic [30:0] heading;
    logic [31:0] velocity_x;
    logic [31:0] velocity_y;
  } pose_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid_i = 1'b0;
  logic         s_tready_o;
  logic [63:0]  s_tdata_i = '0;
  logic         m_tvalid_o;
  logic         m_tready_i = 1'b0;
  logic [159:0] m_tdata_o;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [7:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;

  differential_drive_odometry_core dut (.*);

  always #5 clk_i = ~clk_i;

  // model state and settings
  logic [31:0] start_x_q, start_y_q;
  logic [30:0] start_h_q;
  longint      radius_q, inv_axis_q, inv_step_q;
  logic [31:0] prev_left, prev_right, pos_x, pos_y;
  longint      heading;
  bit          loaded;
  longint      atan_tab[24];

  pose_t pose_queue[$];
  int    errors = 0;
  int    cycles = 0;
  int    send_idle = 0;
  int    recv_idle = 0;

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void build_atan();
    longint unsigned one;
    longint sum, term;
    int e;
    one = 1;
    atan_tab[0] = 210828714;
    for (int i = 1; i < 24; i++) begin
      sum = 0;
      for (int k = 0; k < 64; k++) begin
        e = 60 - i * (2 * k + 1);
        if (e < 0) break;
        term = longint'((one << e) / longint'(2 * k + 1));
        sum += (k & 1) ? -term : term;
      end
      atan_tab[i] = round_shift(sum, 32);
    end
  endfunction

  function automatic void sin_cos(longint h, output longint c, output longint s);
    longint x, y, z, dx, dy;
    bit neg;
    x = Gain; y = 0; z = h; neg = 0;
    if (z > HalfPiQ) begin
      z -= PiQ; neg = 1;
    end else if (z < -HalfPiQ) begin
      z += PiQ; neg = 1;
    end
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic pose_t advance_pose(logic [31:0] left, logic [31:0] right);
    pose_t r;
    longint dl, dr, tl, tr, disp, diff, turn, c, s, px, py, h;
    logic [31:0] tmp;
    if (!loaded) begin
      pos_x = start_x_q;
      pos_y = start_y_q;
      heading = clamp(longint'(signed'(start_h_q)), -PiQ, PiQ);
      loaded = 1;
    end
    tmp = left - prev_left;
    dl = longint'(signed'(tmp));
    tmp = right - prev_right;
    dr = longint'(signed'(tmp));
    prev_left = left;
    prev_right = right;
    tl = dl * radius_q;
    tr = dr * radius_q;
    disp = clamp(round_shift(tl + tr, 9), I32Min, I32Max);
    diff = clamp(tr - tl, -(64'sd1 << 39), 64'sd1 << 39);
    turn = clamp(-round_shift(diff * inv_axis_q, 20), -TwoPiQ, TwoPiQ);
    sin_cos(heading, c, s);
    px = disp * c;
    py = disp * s;
    pos_x = pos_x + 32'(round_shift(px, 30));
    pos_y = pos_y + 32'(round_shift(py, 30));
    h = heading + turn;
    if (h > PiQ) h -= TwoPiQ;
    if (h < -PiQ) h += TwoPiQ;
    heading = h;
    r.pose_x = pos_x;
    r.pose_y = pos_y;
    r.heading = 31'(heading);
    r.velocity_x = 32'(clamp(round_shift(round_shift(px, 24) * inv_step_q, 24),
                             I32Min, I32Max));
    r.velocity_y = 32'(clamp(round_shift(round_shift(py, 24) * inv_step_q, 24),
                             I32Min, I32Max));
    return r;
  endfunction

  task automatic send_angles(logic [31:0] left, logic [31:0] right);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk_i);
      s_tvalid_i = 1'b0;
    end
    @(negedge clk_i);
    s_tvalid_i = 1'b1;
    s_tdata_i = {right, left};
    do @(posedge clk_i); while (!s_tready_o);
    pose_queue.push_back(advance_pose(left, right));
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] value);
    @(negedge clk_i);
    s_tvalid_i = 1'b0;
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_START_X:  start_x_q = value;
      CFG_START_Y:  start_y_q = value;
      CFG_START_H:  start_h_q = value[30:0];
      CFG_RADIUS:   radius_q = value[15:0];
      CFG_INV_AXIS: inv_axis_q = value[23:0];
      CFG_INV_STEP: inv_step_q = value[23:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_tvalid_i = 1'b0;
    wait (pose_queue.size() == 0);
    repeat (Latency) @(posedge clk_i);
  endtask

  task automatic write_motion(int radius, int axis, int step);
    drain();
    write_reg(CFG_RADIUS, radius);
    write_reg(CFG_INV_AXIS, axis);
    write_reg(CFG_INV_STEP, step);
  endtask

  // first beat loads start pose; start heading above pi saturates
  task automatic test_start_pose();
    write_reg(CFG_START_X, 32'h8000_0000);
    write_reg(CFG_START_Y, 32'h7FFF_FFFF);
    write_reg(CFG_START_H, 32'h3FFF_FFFF);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    send_angles(32'h0, 32'h0);
    send_angles(32'h0001_0000, 32'h0002_0000);
    send_angles(32'h0001_0000, 32'h0002_0000);
    drain();
    // no effect after the first beat
    write_reg(CFG_START_X, 32'h1234_5678);
    write_reg(CFG_START_Y, 32'h0);
    write_reg(CFG_START_H, 32'h4000_0000);
    send_angles(32'h0003_0000, 32'h0001_0000);
  endtask

  task automatic test_extremes();
    write_motion(16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF);
    send_angles(32'h7FFF_FFFF, 32'h8000_0000);
    send_angles(32'h8000_0000, 32'h7FFF_FFFF);
    send_angles(32'h5555_5555, 32'hAAAA_AAAA);
    send_angles(32'hAAAA_AAAA, 32'h5555_5555);
    send_angles(32'h2AAA_AAAA, 32'h2AAA_AAAA);
    send_angles(32'hAAAA_AAAA, 32'hAAAA_AAAA);
    send_angles(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_motion(0, 0, 0);
    send_angles(32'h1234_5678, 32'h8765_4321);
    send_angles(32'h0, 32'h0);
    write_motion(1311, 1260308, 524288);
    for (int i = 0; i < 8; i++)
      send_angles(prev_left + 32'h0008_0000, prev_right - 32'h0008_0000);
  endtask

  task automatic test_random_motion(int count);
    logic [31:0] l, r;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) begin
        l = $urandom;
        r = $urandom;
      end else begin
        l = prev_left + 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        r = prev_right + 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      end
      send_angles(l, r);
    end
  endtask

  task automatic test_random_phases();
    send_idle = 27; recv_idle = 86;
    test_random_motion(340);
    write_motion($urandom_range(0, 65535), $urandom_range(0, 24'hFF_FFFF),
                 $urandom_range(0, 24'hFF_FFFF));
    send_idle = 86; recv_idle = 27;
    test_random_motion(340);
    write_motion($urandom_range(500, 4000), $urandom_range(0, 2000000),
                 $urandom_range(0, 24'hFF_FFFF));
    send_idle = 0; recv_idle = 0;
    test_random_motion(340);
  endtask

  always @(negedge clk_i)
    m_tready_i <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk_i) begin
    pose_t got, want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got = '{pose_x: m_tdata_o[31:0], pose_y: m_tdata_o[63:32],
              heading: m_tdata_o[94:64], velocity_x: m_tdata_o[126:95],
              velocity_y: m_tdata_o[158:127]};
      if (pose_queue.size() == 0) begin
        $error("unexpected beat");
        errors++;
      end else begin
        want = pose_queue.pop_front();
        if (got.pose_x !== want.pose_x) begin
          $error("pose_x exp %h got %h", want.pose_x, got.pose_x); errors++;
        end
        if (got.pose_y !== want.pose_y) begin
          $error("pose_y exp %h got %h", want.pose_y, got.pose_y); errors++;
        end
        if (got.heading !== want.heading) begin
          $error("heading exp %h got %h", want.heading, got.heading);
          errors++;
        end
        if (got.velocity_x !== want.velocity_x) begin
          $error("velocity_x exp %h got %h", want.velocity_x, got.velocity_x); errors++;
        end
        if (got.velocity_y !== want.velocity_y) begin
          $error("velocity_y exp %h got %h", want.velocity_y, got.velocity_y); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    start_x_q = '0; start_y_q = '0; start_h_q = '0;
    radius_q = 1311; inv_axis_q = 1260308; inv_step_q = 524288;
    prev_left = '0; prev_right = '0; pos_x = '0; pos_y = '0;
    heading = 0; loaded = 0;
    build_atan();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_start_pose();
    test_extremes();
    test_random_phases();
    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
